/* rtl/core/sqtc_pkg.sv */
// Shared types and constants of the square transposition cipher unit.
`default_nettype none

package sqtc_pkg;

    localparam int MAX_LEN_DEF = 49;

    // Side length of the square; fits the largest supported store (8 x 8).
    localparam int SIDE_W = 4;
    // Width of a scan position row*side+col, at most side*side-1.
    localparam int POS_W = 6;
    // Width of side*side.
    localparam int SQ_W = 2 * SIDE_W;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Register index taken from paddr[2].
    localparam logic CFG_IDX_SPACED = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SIDE,
        ST_SCAN,
        ST_CHAR,
        ST_SPACE,
        ST_EMPTY
    } sqtc_state_t;

    typedef struct packed {
        logic load;       // store the offered text byte
        logic run_init;   // clear side and scan counters
        logic side_inc;   // grow the side length by one
        logic scan_step;  // read at the current position if valid, then advance
        logic char_done;  // one cipher character was taken
        logic run_clear;  // the run is over, forget the text
        logic out_valid;
        logic out_space;
        logic out_empty;
    } sqtc_cmd_t;

    typedef struct packed {
        logic count_zero; // nothing kept
        logic side_short; // side*side below the kept count
        logic pos_hit;    // current position lies inside the text
        logic is_last;    // the character on offer is the final one
        logic grp_full;   // the character on offer closes a group of side
    } sqtc_status_t;

endpackage

`default_nettype wire

/* rtl/core/sqtc_datapath.sv */
// Datapath: character filter, text store, side search and column scan counters.
`default_nettype none

module sqtc_datapath
    import sqtc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    text_byte,
    input  wire sqtc_cmd_t     cmd,
    output sqtc_status_t       status,
    output logic [7:0]         out_byte,
    output logic [SIDE_W-1:0]  column_count,
    output logic               overflow_seen
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [7:0]        text_mem [MAX_LEN];
    logic [7:0]        rd_data_reg;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [SIDE_W-1:0] side_reg, side_next;
    logic [SIDE_W-1:0] row_reg, row_next;
    logic [SIDE_W-1:0] col_reg, col_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic [SIDE_W-1:0] grp_reg, grp_next;

    logic              keep;
    logic [7:0]        kept_char;
    logic              full;
    logic              mem_we;
    logic [SQ_W-1:0]   side_sq;
    logic [SIDE_W-1:0] row_inc;
    logic [SIDE_W-1:0] col_inc;
    logic [SIDE_W-1:0] grp_inc;
    logic [CNT_W-1:0]  emit_inc;

    // Upper-case letters are lowered; everything but letters and digits is dropped.
    always_comb
    begin
        keep      = 1'b1;
        kept_char = text_byte;
        if (text_byte inside {[8'h41:8'h5A]})
            kept_char = text_byte + 8'h20;
        else if (!(text_byte inside {[8'h61:8'h7A], [8'h30:8'h39]}))
            keep = 1'b0;
    end

    assign full     = (cnt_reg == CNT_W'(MAX_LEN));
    assign mem_we   = cmd.load && keep && !full;
    assign side_sq  = SQ_W'(side_reg) * SQ_W'(side_reg);
    assign row_inc  = row_reg + SIDE_W'(1);
    assign col_inc  = col_reg + SIDE_W'(1);
    assign grp_inc  = grp_reg + SIDE_W'(1);
    assign emit_inc = emit_reg + CNT_W'(1);

    assign status.count_zero = (cnt_reg == '0);
    assign status.side_short = (side_sq < SQ_W'(cnt_reg));
    assign status.pos_hit    = (pos_reg < POS_W'(cnt_reg));
    assign status.is_last    = (emit_inc == cnt_reg);
    assign status.grp_full   = (grp_inc == side_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            text_mem[cnt_reg[AW-1:0]] <= kept_char;
        if (cmd.scan_step && status.pos_hit)
            rd_data_reg <= text_mem[pos_reg[AW-1:0]];
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        side_next = side_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        pos_next  = pos_reg;
        emit_next = emit_reg;
        grp_next  = grp_reg;

        if (mem_we)
            cnt_next = cnt_reg + CNT_W'(1);
        if (cmd.load && keep && full)
            ovf_next = 1'b1;
        if (cmd.run_clear)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end

        if (cmd.run_init)
        begin
            side_next = '0;
            row_next  = '0;
            col_next  = '0;
            pos_next  = '0;
            emit_next = '0;
            grp_next  = '0;
        end
        if (cmd.side_inc)
            side_next = side_reg + SIDE_W'(1);

        // Walk down the column; at its foot move to the top of the next one.
        if (cmd.scan_step)
        begin
            if (row_inc == side_reg)
            begin
                row_next = '0;
                col_next = col_inc;
                pos_next = POS_W'(col_inc);
            end
            else
            begin
                row_next = row_inc;
                pos_next = pos_reg + POS_W'(side_reg);
            end
        end

        if (cmd.char_done)
        begin
            emit_next = emit_inc;
            grp_next  = status.grp_full ? '0 : grp_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            side_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            pos_reg  <= '0;
            emit_reg <= '0;
            grp_reg  <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            side_reg <= side_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            pos_reg  <= pos_next;
            emit_reg <= emit_next;
            grp_reg  <= grp_next;
        end
    end

    always_comb
    begin
        if (cmd.out_space)
            out_byte = SPACE_CHAR;
        else if (cmd.out_empty)
            out_byte = 8'h00;
        else
            out_byte = rd_data_reg;
    end

    assign column_count  = side_reg;
    assign overflow_seen = ovf_reg;

endmodule

`default_nettype wire

/* rtl/core/sqtc_controller.sv */
// Controller: sequences loading, side search, column scan and result hand-off.
`default_nettype none

module sqtc_controller
    import sqtc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_last,
    output logic              in_ready,
    input  wire logic         out_ready,
    input  wire logic         spaced,
    input  wire sqtc_status_t status,
    output sqtc_cmd_t         cmd
);

    sqtc_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_last)
                    state_next = ST_START;
            ST_START:
                state_next = status.count_zero ? ST_EMPTY : ST_SIDE;
            ST_SIDE:
                if (!status.side_short)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (status.pos_hit)
                    state_next = ST_CHAR;
            ST_CHAR:
                if (out_ready)
                begin
                    if (status.is_last)
                        state_next = ST_IDLE;
                    else if (spaced && status.grp_full)
                        state_next = ST_SPACE;
                    else
                        state_next = ST_SCAN;
                end
            ST_SPACE:
                if (out_ready)
                    state_next = ST_SCAN;
            ST_EMPTY:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_START:
                cmd.run_init = 1'b1;
            ST_SIDE:
                cmd.side_inc = status.side_short;
            ST_SCAN:
                cmd.scan_step = 1'b1;
            ST_CHAR:
            begin
                cmd.out_valid = 1'b1;
                cmd.char_done = out_ready;
                cmd.run_clear = out_ready && status.is_last;
            end
            ST_SPACE:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_space = 1'b1;
            end
            ST_EMPTY:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_empty = 1'b1;
                cmd.run_clear = out_ready;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/core/square_transposition_cipher_unit.sv */
// Top level of the square transposition cipher unit: stream ports and register port.
//
// Text bytes enter one per cycle while the unit is idle; letters are lowered, anything
// but letters and digits is dropped, and up to MAX_LEN characters are kept (more set
// the overflow flag). The item marked tlast ends the text: after a setup step the side
// length is searched, then the kept characters leave column by column. Each cipher
// character is a read of the text store, then the result on offer; each position of
// the square past the end of the text costs one more scan step, and each space is
// offered on its own; output stalls hold the flow. No new text is taken until the
// last result of a run has been taken. An empty text yields one result with tuser
// set. Register 0 at byte address 0, bit 0, turns on a space after every side-length
// characters.
`default_nettype none

module square_transposition_cipher_unit
    import sqtc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [11:8] column_count,
                                             // [12] overflow_seen, [15:13] zero
    output logic             m_axis_tlast,   // last_out
    output logic             m_axis_tuser,   // empty_text
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    sqtc_cmd_t         cmd;
    sqtc_status_t      status;
    logic              spaced_reg, spaced_next;
    logic [7:0]        out_byte;
    logic [SIDE_W-1:0] column_count;
    logic              overflow_seen;

    assign pready = 1'b1;

    always_comb
    begin
        spaced_next = spaced_reg;
        if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_SPACED)
            spaced_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spaced_reg <= 1'b0;
        else
            spaced_reg <= spaced_next;
    end

    assign prdata = (paddr[2] == CFG_IDX_SPACED) ? {31'd0, spaced_reg} : 32'd0;

    sqtc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .spaced    (spaced_reg),
        .status    (status),
        .cmd       (cmd)
    );

    sqtc_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_byte     (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .out_byte      (out_byte),
        .column_count  (column_count),
        .overflow_seen (overflow_seen)
    );

    assign m_axis_tvalid = cmd.out_valid;
    assign m_axis_tdata  = {3'b000, overflow_seen, column_count, out_byte};
    assign m_axis_tlast  = cmd.out_empty || (!cmd.out_space && status.is_last);
    assign m_axis_tuser  = cmd.out_empty;

endmodule

`default_nettype wire
